// File: rtl/cfpr_pkg.sv
// ----------------------------------------------------------------------------
// cfpr_pkg: shared definitions for the framed packet receiver
// Sizes derived from the frame buffer, status codes, result item type and
// the reflected ccitt crc byte update.
// ----------------------------------------------------------------------------
package cfpr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int HEADER_BYTES = 4;

  // byte counter reaches at most the whole frame size, length at most the payload room
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W = $clog2(BUFFER_BYTES - HEADER_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_LEN_BAD    = 3'd1,
    ST_CRC_LO_BAD = 3'd2,
    ST_CRC_HI_BAD = 3'd3,
    ST_GOOD       = 3'd4
  } status_t;

  typedef struct packed {
    logic        more_expected;
    status_t     status;
    logic        payload_strobe;
    logic [7:0]  payload_data;
    logic [5:0]  payload_offset;
    logic [7:0]  msg_id;
    logic [7:0]  comp_id;
    logic [5:0]  payload_length;
  } result_t;

  // reflected update, one bit per step
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/cfpr_parser.sv
// ----------------------------------------------------------------------------
// cfpr_parser: frame state and per-byte result
// Holds the byte position, length, ids and running crc; forms the result
// item for the current byte and advances the state when the byte is taken.
// ----------------------------------------------------------------------------
module cfpr_parser
  import cfpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_data,
  output result_t    res
);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]       held_msg_id, held_msg_id_next;
  logic [7:0]       held_comp_id, held_comp_id_next;
  logic [15:0]      running_crc, running_crc_next;

  logic [CNT_W-1:0] crc_lo_idx;
  logic [8:0]       frame_total;
  logic [15:0]      crc_step;
  logic             advance;

  assign crc_lo_idx  = CNT_W'(HEADER_BYTES - 1) + CNT_W'(frame_length);
  assign frame_total = {1'b0, rx_data} + 9'(HEADER_BYTES);

  always_comb begin
    res               = '0;
    res.status        = ST_ACCEPTED;
    advance           = 1'b1;
    frame_length_next = frame_length;
    held_msg_id_next  = held_msg_id;
    held_comp_id_next = held_comp_id;
    running_crc_next  = running_crc;
    crc_step          = crc_update((byte_count == '0) ? CRC_INIT : running_crc, rx_data);

    if (byte_count == '0) begin
      if (frame_total > 9'(BUFFER_BYTES)) begin
        res.status = ST_LEN_BAD;
        advance    = 1'b0;
      end else begin
        frame_length_next = LEN_W'(rx_data);
        running_crc_next  = crc_step;
      end
    end else if (byte_count == CNT_W'(1)) begin
      held_msg_id_next = rx_data;
      running_crc_next = crc_step;
    end else if (byte_count == CNT_W'(2)) begin
      held_comp_id_next = rx_data;
      running_crc_next  = crc_step;
    end else if (byte_count < crc_lo_idx) begin
      running_crc_next   = crc_step;
      res.payload_strobe = 1'b1;
      res.payload_data   = rx_data;
      res.payload_offset = 6'(byte_count - CNT_W'(3));
    end else if (byte_count == crc_lo_idx) begin
      if (rx_data != running_crc[7:0]) begin
        res.status = ST_CRC_LO_BAD;
        advance    = 1'b0;
      end
    end else begin
      if (rx_data == running_crc[15:8]) begin
        res.status         = ST_GOOD;
        res.msg_id         = held_msg_id;
        res.comp_id        = held_comp_id;
        res.payload_length = 6'(frame_length);
      end else begin
        res.status = ST_CRC_HI_BAD;
      end
      advance = 1'b0;
    end

    res.more_expected = advance;
    byte_count_next   = advance ? byte_count + CNT_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_length <= '0;
      held_msg_id  <= '0;
      held_comp_id <= '0;
      running_crc  <= CRC_INIT;
    end else if (take) begin
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      held_msg_id  <= held_msg_id_next;
      held_comp_id <= held_comp_id_next;
      running_crc  <= running_crc_next;
    end
  end

  // a payload byte never ends the frame
  a_strobe_continues: assert property (@(posedge clk) disable iff (rst)
    res.payload_strobe |-> (res.more_expected && res.status == ST_ACCEPTED))
    else $error("payload byte reported with ending status");

  // a taken byte that ends the frame returns the counter to the length byte
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && !res.more_expected) |=> (byte_count == '0))
    else $error("byte counter not cleared after frame end");

endmodule

// File: rtl/crc_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver: length-prefixed frame receiver with crc-16
// Byte-by-byte parser of frames that follow a start character, checking a
// reflected ccitt crc and reporting one result item per byte.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_ready carry rx_data, one received byte per item.
//   out channel : out_valid / out_ready carry one result item per input byte:
//                 more_expected, status, the payload strobe with data and
//                 offset, and msg_id / comp_id / payload_length with frame good.
//   The result of a byte taken at an edge is registered at that edge and shown
//   from it on, unless the output stalls and it is parked in the skid register.
//   Throughput is one byte per cycle while in_ready is high; the crc byte update
//   and the position checks sit between the frame state and the result register.
//   When the receiver stalls, a second result is parked in a skid register,
//   so one more byte is taken; in_ready drops only while that skid is full.
//   Reset clears the valid flags of both result registers, returns the parser
//   to waiting for a length byte and sets the running crc to 0xFFFF.
// ----------------------------------------------------------------------------
module crc_framed_packet_receiver
  import cfpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       more_expected,
  output logic [2:0] status,
  output logic       payload_strobe,
  output logic [7:0] payload_data,
  output logic [5:0] payload_offset,
  output logic [7:0] msg_id,
  output logic [7:0] comp_id,
  output logic [5:0] payload_length
);

  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    take;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  cfpr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_data (rx_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!take) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= take;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (take) begin
        out_res <= res;
      end
    end else if (!out_valid) begin
      if (take) begin
        out_res <= res;
      end
    end else if (take) begin
      skid_res <= res;
    end
  end

  assign more_expected  = out_res.more_expected;
  assign status         = out_res.status;
  assign payload_strobe = out_res.payload_strobe;
  assign payload_data   = out_res.payload_data;
  assign payload_offset = out_res.payload_offset;
  assign msg_id         = out_res.msg_id;
  assign comp_id        = out_res.comp_id;
  assign payload_length = out_res.payload_length;

  // the skid only ever holds the item behind the shown one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item with no item shown");

  // a byte taken while the output stalls must land in the skid
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (take && out_valid && !out_ready) |=> skid_valid)
    else $error("item taken under stall was dropped");

endmodule
